// ===== design/pjs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjs_pkg
// Shared types, codes and helpers of the priority job scheduler.
// ----------------------------------------------------------------------------
package pjs_pkg;

   localparam int IDX_W = 9;

   localparam logic [1:0] KIND_ENQ   = 2'd0;
   localparam logic [1:0] KIND_FIN   = 2'd1;
   localparam logic [1:0] KIND_ABORT = 2'd2;
   localparam logic [1:0] KIND_DRAIN = 2'd3;

   localparam logic [1:0] EV_START  = 2'd0;
   localparam logic [1:0] EV_FINISH = 2'd1;
   localparam logic [1:0] EV_CANCEL = 2'd2;
   localparam logic [1:0] EV_DONE   = 2'd3;

   localparam logic [3:0] OP_NOP  = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;
   localparam logic [3:0] OP_DQ   = 4'd2;
   localparam logic [3:0] OP_DA   = 4'd3;
   localparam logic [3:0] OP_PP   = 4'd4;
   localparam logic [3:0] OP_PA   = 4'd5;
   localparam logic [3:0] OP_INS  = 4'd6;
   localparam logic [3:0] OP_BCLR = 4'd7;
   localparam logic [3:0] OP_BS   = 4'd8;
   localparam logic [3:0] OP_BT   = 4'd9;
   localparam logic [3:0] OP_FS   = 4'd10;
   localparam logic [3:0] OP_FR   = 4'd11;
   localparam logic [3:0] OP_AA   = 4'd12;
   localparam logic [3:0] OP_DONE = 4'd13;
   localparam logic [3:0] OP_OUT  = 4'd14;

   typedef struct packed {
      logic [7:0]        tag;
      logic signed [7:0] prio;
      logic              bg;
      logic              canc;
      logic              haskey;
      logic [15:0]       key;
      logic [31:0]       seq;
   } job_type;

   typedef struct packed {
      job_type job;
      logic    ab;
   } slot_type;

   typedef struct packed {
      logic [1:0] res;
      logic [7:0] tag;
      logic       bg;
      logic       ab;
      logic       ovf;
   } event_type;

   typedef struct packed {
      logic [3:0]       op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             free_found;
      logic             need_preempt;
      logic             best_found;
      logic             can_fill;
      logic             fin_found;
      logic [IDX_W-1:0] ev_count;
   } status_type;

   function automatic logic better(job_type a, job_type b);
      logic r;
      if (a.prio != b.prio) r = (a.prio > b.prio);
      else if (a.bg != b.bg) r = !a.bg;
      else r = (a.seq < b.seq);
      return r;
   endfunction

endpackage

// ===== design/pjs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjs_ctrl
// Sequencer: walks queue and slot scans and issues datapath commands.
// ----------------------------------------------------------------------------
module pjs_ctrl #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_ACTIVE  = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pjs_pkg::status_type  stat,
   output pjs_pkg::cmd_type     cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_DQ    = 5'd2;
   localparam logic [4:0] S_DA    = 5'd3;
   localparam logic [4:0] S_EDEC  = 5'd4;
   localparam logic [4:0] S_PP    = 5'd5;
   localparam logic [4:0] S_PA    = 5'd6;
   localparam logic [4:0] S_INS   = 5'd7;
   localparam logic [4:0] S_DRAIN = 5'd8;
   localparam logic [4:0] S_BS    = 5'd9;
   localparam logic [4:0] S_BT    = 5'd10;
   localparam logic [4:0] S_FS    = 5'd11;
   localparam logic [4:0] S_FDEC  = 5'd12;
   localparam logic [4:0] S_FR    = 5'd13;
   localparam logic [4:0] S_AA    = 5'd14;
   localparam logic [4:0] S_DONE  = 5'd15;
   localparam logic [4:0] S_OUT   = 5'd16;

   localparam logic [pjs_pkg::IDX_W-1:0] QLIM = pjs_pkg::IDX_W'(QUEUE_DEPTH);
   localparam logic [pjs_pkg::IDX_W-1:0] SLIM = pjs_pkg::IDX_W'(MAX_ACTIVE);

   logic [4:0]                state_ff, state_in;
   logic [pjs_pkg::IDX_W-1:0] i_ff, i_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      cmd.op   = pjs_pkg::OP_NOP;
      cmd.idx  = i_ff;
      unique case (state_ff)
         S_IDLE: begin
            i_in = '0;
            if (start) begin
               cmd.op   = pjs_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.kind)
               pjs_pkg::KIND_ENQ:   state_in = S_DQ;
               pjs_pkg::KIND_FIN:   state_in = S_FS;
               pjs_pkg::KIND_ABORT: state_in = S_AA;
               default:             state_in = S_DRAIN;
            endcase
         end
         S_DQ: begin
            // the final pass issues no command so the last registered read can finish
            if (i_ff == QLIM) begin
               i_in     = '0;
               state_in = S_DA;
            end else begin
               cmd.op = pjs_pkg::OP_DQ;
               i_in   = i_ff + 1'b1;
            end
         end
         S_DA: begin
            if (i_ff == SLIM) begin
               i_in     = '0;
               state_in = S_EDEC;
            end else begin
               cmd.op = pjs_pkg::OP_DA;
               i_in   = i_ff + 1'b1;
            end
         end
         S_EDEC: begin
            if (!stat.free_found) state_in = S_DRAIN;
            else if (stat.need_preempt) state_in = S_PP;
            else state_in = S_INS;
         end
         S_PP: begin
            if (i_ff == SLIM) begin
               i_in     = '0;
               state_in = S_PA;
            end else begin
               cmd.op = pjs_pkg::OP_PP;
               i_in   = i_ff + 1'b1;
            end
         end
         S_PA: begin
            cmd.op   = pjs_pkg::OP_PA;
            state_in = S_INS;
         end
         S_INS: begin
            cmd.op   = pjs_pkg::OP_INS;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            i_in = '0;
            if (stat.can_fill) begin
               cmd.op   = pjs_pkg::OP_BCLR;
               state_in = S_BS;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BS: begin
            if (i_ff == QLIM) begin
               i_in     = '0;
               state_in = S_BT;
            end else begin
               cmd.op = pjs_pkg::OP_BS;
               i_in   = i_ff + 1'b1;
            end
         end
         S_BT: begin
            if (stat.best_found) begin
               cmd.op   = pjs_pkg::OP_BT;
               state_in = S_DRAIN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FS: begin
            if (i_ff == SLIM) begin
               i_in     = '0;
               state_in = S_FDEC;
            end else begin
               cmd.op = pjs_pkg::OP_FS;
               i_in   = i_ff + 1'b1;
            end
         end
         S_FDEC: begin
            state_in = stat.fin_found ? S_FR : S_DONE;
         end
         S_FR: begin
            cmd.op   = pjs_pkg::OP_FR;
            state_in = S_DRAIN;
         end
         S_AA: begin
            if (i_ff == SLIM) begin
               i_in     = '0;
               state_in = S_DONE;
            end else begin
               cmd.op = pjs_pkg::OP_AA;
               i_in   = i_ff + 1'b1;
            end
         end
         S_DONE: begin
            cmd.op   = pjs_pkg::OP_DONE;
            i_in     = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (i_ff == stat.ev_count) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = pjs_pkg::OP_OUT;
               i_in   = i_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
      end
   end

endmodule

// ===== design/pjs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pjs_datapath
// Wait queue, active slots, counters, event buffer and config register.
// ----------------------------------------------------------------------------
module pjs_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_ACTIVE  = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pjs_pkg::cmd_type     cmd,
   output pjs_pkg::status_type  stat,
   input  logic [1:0]           req_kind,
   input  logic [7:0]           req_job_tag,
   input  logic signed [7:0]    req_priority_req,
   input  logic                 req_background,
   input  logic                 req_cancellable,
   input  logic                 req_has_key,
   input  logic [15:0]          req_dedupe_key,
   input  logic                 req_net_cancelled,
   input  logic                 cfg_we,
   input  logic [2:0]           cfg_wdata,
   output logic [2:0]           cfg_max,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_event_res,
   output logic [7:0]           rsp_event_tag,
   output logic                 rsp_event_background,
   output logic                 rsp_was_aborted,
   output logic [2:0]           rsp_active_count,
   output logic [4:0]           rsp_queued_count,
   output logic [31:0]          rsp_aborted_total,
   output logic [31:0]          rsp_throttled_total,
   output logic                 rsp_queue_overflow,
   output logic                 rsp_last
);

   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int SLW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
   localparam int NW  = $clog2(MAX_ACTIVE + 1);
   localparam int RESULT_CAP = 2 * MAX_ACTIVE + 1;
   localparam int EW  = $clog2(RESULT_CAP);
   localparam int ECW = $clog2(RESULT_CAP + 1);
   localparam logic [2:0] MA_CLAMP = (MAX_ACTIVE > 7) ? 3'd7 : 3'(MAX_ACTIVE);

   // request latch
   logic [1:0]        kind_ff, kind_in;
   pjs_pkg::job_type  req_ff, req_in;
   logic              netc_ff, netc_in;

   // queue
   pjs_pkg::job_type  q_mem [QUEUE_DEPTH];
   pjs_pkg::job_type  q_rd_ff;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [QCW-1:0]    q_cnt_ff, q_cnt_in;
   logic              q_we;
   logic [QW-1:0]     q_waddr;
   pjs_pkg::job_type  q_wdata;
   logic [3:0]        op_d_ff;
   logic [QW-1:0]     idx_d_ff;

   // slots
   pjs_pkg::slot_type slots_ff [MAX_ACTIVE];
   pjs_pkg::slot_type slots_in [MAX_ACTIVE];
   logic [NW-1:0]     n_act_ff, n_act_in;

   // scan results
   logic              free_ff, free_in;
   logic [QW-1:0]     free_idx_ff, free_idx_in;
   logic              pick_ff, pick_in;
   logic [SLW-1:0]    pick_idx_ff, pick_idx_in;
   logic              best_ff, best_in;
   logic [QW-1:0]     best_idx_ff, best_idx_in;
   pjs_pkg::job_type  best_rec_ff, best_rec_in;
   logic              fin_ff, fin_in;
   logic [SLW-1:0]    fin_idx_ff, fin_idx_in;

   // counters
   logic [31:0]       seq_ff, seq_in;
   logic [31:0]       abt_ff, abt_in;
   logic [31:0]       thr_ff, thr_in;
   logic [2:0]        maxc_ff, maxc_in;

   // event buffer
   pjs_pkg::event_type ev_mem [RESULT_CAP];
   pjs_pkg::event_type ev_rd_ff;
   logic [ECW-1:0]    ev_cnt_ff, ev_cnt_in;
   logic              ev_we;
   pjs_pkg::event_type ev_wdata;
   logic              rsp_valid_ff;
   logic              last_ff;

   pjs_pkg::slot_type cur_slot;
   pjs_pkg::slot_type fin_slot;
   logic              in_range;
   logic [4:0]        na5;
   logic [4:0]        mc5;
   logic              dq_match;

   assign na5      = 5'(n_act_ff);
   assign mc5      = {2'b00, maxc_ff};
   assign cur_slot = slots_ff[cmd.idx[SLW-1:0]];
   assign fin_slot = slots_ff[fin_idx_ff];
   assign in_range = (cmd.idx < pjs_pkg::IDX_W'(n_act_ff));
   assign dq_match = req_ff.haskey && valid_ff[idx_d_ff] && q_rd_ff.haskey &&
                     (q_rd_ff.key == req_ff.key);

   assign stat.kind         = kind_ff;
   assign stat.free_found   = free_ff;
   assign stat.need_preempt = !req_ff.bg && (na5 >= mc5);
   assign stat.best_found   = best_ff;
   assign stat.can_fill     = (na5 < mc5) && (na5 < 5'(MAX_ACTIVE));
   assign stat.fin_found    = fin_ff;
   assign stat.ev_count     = pjs_pkg::IDX_W'(ev_cnt_ff);

   assign cfg_max = maxc_ff;

   always_comb begin
      kind_in     = kind_ff;
      req_in      = req_ff;
      netc_in     = netc_ff;
      valid_in    = valid_ff;
      q_cnt_in    = q_cnt_ff;
      n_act_in    = n_act_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      pick_in     = pick_ff;
      pick_idx_in = pick_idx_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      best_rec_in = best_rec_ff;
      fin_in      = fin_ff;
      fin_idx_in  = fin_idx_ff;
      seq_in      = seq_ff;
      abt_in      = abt_ff;
      thr_in      = thr_ff;
      maxc_in     = maxc_ff;
      ev_cnt_in   = ev_cnt_ff;
      ev_we       = 1'b0;
      ev_wdata    = '0;
      q_we        = 1'b0;
      q_waddr     = free_idx_ff;
      q_wdata     = req_ff;
      q_wdata.seq = seq_ff;
      for (int k = 0; k < MAX_ACTIVE; k++) slots_in[k] = slots_ff[k];

      if (cfg_we) begin
         if (cfg_wdata == 3'd0) maxc_in = 3'd1;
         else if (cfg_wdata > MA_CLAMP) maxc_in = MA_CLAMP;
         else maxc_in = cfg_wdata;
      end

      case (cmd.op)
         pjs_pkg::OP_LOAD: begin
            kind_in     = req_kind;
            req_in.tag  = req_job_tag;
            req_in.prio = req_priority_req;
            req_in.bg   = req_background;
            req_in.canc = req_cancellable;
            req_in.haskey = req_has_key;
            req_in.key  = req_dedupe_key;
            req_in.seq  = '0;
            netc_in     = req_net_cancelled;
            free_in     = 1'b0;
            pick_in     = 1'b0;
            best_in     = 1'b0;
            fin_in      = 1'b0;
            ev_cnt_in   = '0;
         end
         pjs_pkg::OP_DA: begin
            if (in_range && req_ff.haskey && req_ff.bg && cur_slot.job.bg &&
                cur_slot.job.canc && cur_slot.job.haskey &&
                (cur_slot.job.key == req_ff.key) && !cur_slot.ab) begin
               slots_in[cmd.idx[SLW-1:0]].ab = 1'b1;
               if (abt_ff != '1) abt_in = abt_ff + 1'b1;
               ev_we     = 1'b1;
               ev_wdata  = '{res: pjs_pkg::EV_CANCEL, tag: cur_slot.job.tag,
                             bg: cur_slot.job.bg, ab: 1'b0, ovf: 1'b0};
               ev_cnt_in = ev_cnt_ff + 1'b1;
            end
         end
         pjs_pkg::OP_PP: begin
            if (in_range && cur_slot.job.bg && cur_slot.job.canc && !cur_slot.ab &&
                (!pick_ff || (cur_slot.job.seq < slots_ff[pick_idx_ff].job.seq))) begin
               pick_in     = 1'b1;
               pick_idx_in = cmd.idx[SLW-1:0];
            end
         end
         pjs_pkg::OP_PA: begin
            if (pick_ff) begin
               slots_in[pick_idx_ff].ab = 1'b1;
               if (abt_ff != '1) abt_in = abt_ff + 1'b1;
               ev_we     = 1'b1;
               ev_wdata  = '{res: pjs_pkg::EV_CANCEL, tag: slots_ff[pick_idx_ff].job.tag,
                             bg: slots_ff[pick_idx_ff].job.bg, ab: 1'b0, ovf: 1'b0};
               ev_cnt_in = ev_cnt_ff + 1'b1;
            end
         end
         pjs_pkg::OP_INS: begin
            q_we                  = 1'b1;
            valid_in[free_idx_ff] = 1'b1;
            q_cnt_in              = q_cnt_ff + 1'b1;
            seq_in                = seq_ff + 1'b1;
         end
         pjs_pkg::OP_BCLR: best_in = 1'b0;
         pjs_pkg::OP_BT: begin
            slots_in[n_act_ff[SLW-1:0]].job = best_rec_ff;
            slots_in[n_act_ff[SLW-1:0]].ab  = 1'b0;
            n_act_in              = n_act_ff + 1'b1;
            valid_in[best_idx_ff] = 1'b0;
            q_cnt_in              = q_cnt_ff - 1'b1;
            best_in               = 1'b0;
            ev_we     = 1'b1;
            ev_wdata  = '{res: pjs_pkg::EV_START, tag: best_rec_ff.tag,
                          bg: best_rec_ff.bg, ab: 1'b0, ovf: 1'b0};
            ev_cnt_in = ev_cnt_ff + 1'b1;
         end
         pjs_pkg::OP_FS: begin
            if (in_range && !fin_ff && (cur_slot.job.tag == req_ff.tag)) begin
               fin_in     = 1'b1;
               fin_idx_in = cmd.idx[SLW-1:0];
            end
         end
         pjs_pkg::OP_FR: begin
            // close the gap: later slots move down one place
            for (int k = 0; k < MAX_ACTIVE - 1; k++) begin
               if (SLW'(k) >= fin_idx_ff) slots_in[k] = slots_ff[k + 1];
            end
            n_act_in  = n_act_ff - 1'b1;
            ev_we     = 1'b1;
            ev_wdata  = '{res: pjs_pkg::EV_FINISH, tag: fin_slot.job.tag,
                          bg: fin_slot.job.bg, ab: fin_slot.ab || netc_ff, ovf: 1'b0};
            ev_cnt_in = ev_cnt_ff + 1'b1;
         end
         pjs_pkg::OP_AA: begin
            if (cmd.idx == '0) begin
               valid_in = '0;
               q_cnt_in = '0;
            end
            if (in_range) begin
               slots_in[cmd.idx[SLW-1:0]].ab = 1'b1;
               if (!cur_slot.ab) begin
                  ev_we     = 1'b1;
                  ev_wdata  = '{res: pjs_pkg::EV_CANCEL, tag: cur_slot.job.tag,
                                bg: cur_slot.job.bg, ab: 1'b0, ovf: 1'b0};
                  ev_cnt_in = ev_cnt_ff + 1'b1;
               end
            end
         end
         pjs_pkg::OP_DONE: begin
            ev_we        = 1'b1;
            ev_wdata.res = pjs_pkg::EV_DONE;
            ev_wdata.tag = (kind_ff == pjs_pkg::KIND_ENQ || kind_ff == pjs_pkg::KIND_FIN) ?
                           req_ff.tag : 8'd0;
            ev_wdata.bg  = (kind_ff == pjs_pkg::KIND_ENQ) ? req_ff.bg : 1'b0;
            ev_wdata.ab  = 1'b0;
            ev_wdata.ovf = (kind_ff == pjs_pkg::KIND_ENQ) && !free_ff;
            ev_cnt_in    = ev_cnt_ff + 1'b1;
         end
         default: ;
      endcase

      // queue scans act in the cycle after their command, on the registered read
      case (op_d_ff)
         pjs_pkg::OP_DQ: begin
            if (dq_match) begin
               valid_in[idx_d_ff] = 1'b0;
               q_cnt_in           = q_cnt_ff - 1'b1;
               if (q_rd_ff.bg && thr_ff != '1) thr_in = thr_ff + 1'b1;
            end
            if (!free_ff && (!valid_ff[idx_d_ff] || dq_match)) begin
               free_in     = 1'b1;
               free_idx_in = idx_d_ff;
            end
         end
         pjs_pkg::OP_BS: begin
            if (valid_ff[idx_d_ff] &&
                (!best_ff || pjs_pkg::better(q_rd_ff, best_rec_ff))) begin
               best_in     = 1'b1;
               best_idx_in = idx_d_ff;
               best_rec_in = q_rd_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         q_cnt_ff     <= '0;
         n_act_ff     <= '0;
         seq_ff       <= '0;
         abt_ff       <= '0;
         thr_ff       <= '0;
         maxc_ff      <= 3'd1;
         ev_cnt_ff    <= '0;
         op_d_ff      <= pjs_pkg::OP_NOP;
         free_ff      <= 1'b0;
         pick_ff      <= 1'b0;
         best_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         kind_ff      <= pjs_pkg::KIND_DRAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         q_cnt_ff     <= q_cnt_in;
         n_act_ff     <= n_act_in;
         seq_ff       <= seq_in;
         abt_ff       <= abt_in;
         thr_ff       <= thr_in;
         maxc_ff      <= maxc_in;
         ev_cnt_ff    <= ev_cnt_in;
         op_d_ff      <= cmd.op;
         free_ff      <= free_in;
         pick_ff      <= pick_in;
         best_ff      <= best_in;
         fin_ff       <= fin_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= (cmd.op == pjs_pkg::OP_OUT);
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      netc_ff     <= netc_in;
      free_idx_ff <= free_idx_in;
      pick_idx_ff <= pick_idx_in;
      best_idx_ff <= best_idx_in;
      best_rec_ff <= best_rec_in;
      fin_idx_ff  <= fin_idx_in;
      idx_d_ff    <= cmd.idx[QW-1:0];
      last_ff     <= (cmd.idx == pjs_pkg::IDX_W'(ev_cnt_ff - 1'b1));
      for (int k = 0; k < MAX_ACTIVE; k++) slots_ff[k] <= slots_in[k];
   end

   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      q_rd_ff <= q_mem[cmd.idx[QW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ev_we) ev_mem[ev_cnt_ff[EW-1:0]] <= ev_wdata;
      if (cmd.op == pjs_pkg::OP_OUT) ev_rd_ff <= ev_mem[cmd.idx[EW-1:0]];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_res        = ev_rd_ff.res;
   assign rsp_event_tag        = ev_rd_ff.tag;
   assign rsp_event_background = ev_rd_ff.bg;
   assign rsp_was_aborted      = ev_rd_ff.ab;
   assign rsp_queue_overflow   = ev_rd_ff.ovf;
   assign rsp_last             = last_ff;
   assign rsp_active_count     = 3'(n_act_ff);
   assign rsp_queued_count     = 5'(q_cnt_ff);
   assign rsp_aborted_total    = abt_ff;
   assign rsp_throttled_total  = thr_ff;

endmodule

// ===== design/priority_job_scheduler_with_preemption.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_job_scheduler_with_preemption
// An item runs a queue scan per fill (an enqueue also one for dedupe) and
// slot scans, then plays its results out one per cycle. It takes one item
// at a time; busy stays high until the last result. Results cannot be
// stalled. Synchronous reset empties queue and slots.
// ----------------------------------------------------------------------------
module priority_job_scheduler_with_preemption #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_ACTIVE  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_job_tag,
   input  logic signed [7:0]  req_priority_req,
   input  logic               req_background,
   input  logic               req_cancellable,
   input  logic               req_has_key,
   input  logic [15:0]        req_dedupe_key,
   input  logic               req_net_cancelled,
   output logic               rsp_valid,
   output logic [1:0]         rsp_event_res,
   output logic [7:0]         rsp_event_tag,
   output logic               rsp_event_background,
   output logic               rsp_was_aborted,
   output logic [2:0]         rsp_active_count,
   output logic [4:0]         rsp_queued_count,
   output logic [31:0]        rsp_aborted_total,
   output logic [31:0]        rsp_throttled_total,
   output logic               rsp_queue_overflow,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   pjs_pkg::cmd_type    cmd;
   pjs_pkg::status_type stat;
   logic                cfg_we;
   logic [2:0]          cfg_max;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
   assign prdata = (paddr == 2'd0) ? {29'd0, cfg_max} : 32'd0;

   pjs_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .MAX_ACTIVE (MAX_ACTIVE)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   pjs_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .MAX_ACTIVE (MAX_ACTIVE)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_kind),
      .req_job_tag         (req_job_tag),
      .req_priority_req    (req_priority_req),
      .req_background      (req_background),
      .req_cancellable     (req_cancellable),
      .req_has_key         (req_has_key),
      .req_dedupe_key      (req_dedupe_key),
      .req_net_cancelled   (req_net_cancelled),
      .cfg_we              (cfg_we),
      .cfg_wdata           (pwdata[2:0]),
      .cfg_max             (cfg_max),
      .rsp_valid           (rsp_valid),
      .rsp_event_res       (rsp_event_res),
      .rsp_event_tag       (rsp_event_tag),
      .rsp_event_background(rsp_event_background),
      .rsp_was_aborted     (rsp_was_aborted),
      .rsp_active_count    (rsp_active_count),
      .rsp_queued_count    (rsp_queued_count),
      .rsp_aborted_total   (rsp_aborted_total),
      .rsp_throttled_total (rsp_throttled_total),
      .rsp_queue_overflow  (rsp_queue_overflow),
      .rsp_last            (rsp_last)
   );

endmodule
